// ----- rtl/vra_pkg.sv -----
package vra_pkg;

    localparam int ADDR_W   = 32;
    localparam int PAGES_W  = 21;
    localparam int BASE_W   = 20;
    localparam int FREE_W   = 33;

    localparam logic [ADDR_W-1:0] POOL_BASE_RST  = 32'd0;
    localparam logic [ADDR_W-1:0] POOL_BYTES_RST = 32'd4194304;

    typedef enum logic [1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_CHECK   = 2'd2,
        REQ_NONE    = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_TOO_LARGE = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic {
        CFG_POOL_BASE  = 1'b0,
        CFG_POOL_BYTES = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic clear_all;
        logic set;
        logic clr;
    } slot_ctl_t;

endpackage

// ----- rtl/vra_ram.sv -----
module vra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/vra_slot_flags.sv -----
module vra_slot_flags
    import vra_pkg::*;
#(
    parameter int SLOTS = 16,
    parameter int IDX_W = $clog2(SLOTS)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  slot_ctl_t        ctl,
    input  logic [IDX_W-1:0] clr_idx,
    output logic [SLOTS-1:0] valid,
    output logic             free_found,
    output logic [IDX_W-1:0] free_idx
);

    logic [SLOTS-1:0] valid_reg;
    logic [SLOTS-1:0] valid_next;

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (ctl.clear_all) begin
            valid_next = '0;
        end else begin
            if (ctl.set && free_found) begin
                valid_next[free_idx] = 1'b1;
            end
            if (ctl.clr) begin
                valid_next[clr_idx] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign valid = valid_reg;

endmodule

// ----- rtl/virtual_region_allocator_unit.sv -----
// a request is taken in idle, then runs in the alloc or check state, or for a
// release in the search state with its one-entry-per-cycle slot table walk, then
// waits in done to register the result beat; the next request waits for idle
// reset loads the default pool registers, clears control and valid bits, sets the
// bump pointer to one and the free count to the pool minus one page
// the table ram is not cleared and needs no clearing pass
module virtual_region_allocator_unit
    import vra_pkg::*;
#(
    parameter int REGION_SLOTS = 16,
    parameter int PAGE_BYTES   = 4096
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_req_type,
    input  logic [ADDR_W-1:0]   s_size_bytes,
    input  logic [ADDR_W-1:0]   s_address,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic [ADDR_W-1:0]   m_region_start,
    output logic [PAGES_W-1:0]  m_region_pages,
    output logic                m_legitimate,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [ADDR_W-1:0]   cfg_wdata
);

    localparam int SLOT_W     = $clog2(REGION_SLOTS);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int NEED_W     = FREE_W - PAGE_SHIFT;
    localparam int POOL_PG_W  = ADDR_W - PAGE_SHIFT;
    localparam int SUM_W      = ((NEED_W > PAGES_W) ? NEED_W : PAGES_W) + 1;
    localparam int ENTRY_W    = BASE_W + PAGES_W;
    localparam logic [FREE_W-1:0] ONE_PAGE  = FREE_W'(PAGE_BYTES);
    localparam logic [FREE_W-1:0] PAGE_MASK = FREE_W'(PAGE_BYTES - 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(REGION_SLOTS - 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_ALLOC  = 5'b00010,
        ST_SEARCH = 5'b00100,
        ST_CHECK  = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    req_t                 req_reg, req_next;
    logic [ADDR_W-1:0]    size_reg, size_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [ADDR_W-1:0]    pool_base_reg, pool_base_next;
    logic [ADDR_W-1:0]    pool_bytes_reg, pool_bytes_next;
    logic [PAGES_W-1:0]   bump_reg, bump_next;
    logic [FREE_W-1:0]    free_reg, free_next;
    logic [SLOT_W-1:0]    cmp_idx_reg, cmp_idx_next;
    status_t              res_status_reg, res_status_next;
    logic [ADDR_W-1:0]    res_start_reg, res_start_next;
    logic [PAGES_W-1:0]   res_pages_reg, res_pages_next;
    logic                 res_legit_reg, res_legit_next;
    logic                 m_valid_reg, m_valid_next;
    status_t              m_status_reg, m_status_next;
    logic [ADDR_W-1:0]    m_start_reg, m_start_next;
    logic [PAGES_W-1:0]   m_pages_reg, m_pages_next;
    logic                 m_legit_reg, m_legit_next;

    logic [FREE_W-1:0]    rounded;
    logic [FREE_W-1:0]    rounded_pg;
    logic [NEED_W-1:0]    need;
    logic [POOL_PG_W-1:0] pool_pages;
    logic [SUM_W-1:0]     bump_sum;
    logic                 too_big;
    logic                 past_end;
    logic [ADDR_W-1:0]    bump_addr;

    logic [ENTRY_W-1:0]   rd_data;
    logic [ENTRY_W-1:0]   wr_data;
    logic [SLOT_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [BASE_W-1:0]    ent_base;
    logic [PAGES_W-1:0]   ent_pages;
    logic [ADDR_W-1:0]    ent_addr;
    logic [FREE_W-1:0]    credit;
    logic                 hit;
    logic                 in_pool;

    logic [ADDR_W-1:0]    new_bytes;
    logic [FREE_W-1:0]    init_free;

    slot_ctl_t            slot_ctl;
    logic [REGION_SLOTS-1:0] slot_valid;
    logic                 free_found;
    logic [SLOT_W-1:0]    free_idx;

    // allocate datapath
    assign rounded    = {1'b0, size_reg} + PAGE_MASK;
    assign rounded_pg = rounded & ~PAGE_MASK;
    assign need       = NEED_W'(rounded >> PAGE_SHIFT);
    assign pool_pages = POOL_PG_W'(pool_bytes_reg >> PAGE_SHIFT);
    assign bump_sum   = SUM_W'(bump_reg) + SUM_W'(need);
    assign too_big    = rounded_pg > free_reg;
    assign past_end   = bump_sum > SUM_W'(pool_pages);
    assign bump_addr  = pool_base_reg + (ADDR_W'(bump_reg) << PAGE_SHIFT);

    // release datapath
    assign ent_base  = rd_data[ENTRY_W-1:PAGES_W];
    assign ent_pages = rd_data[PAGES_W-1:0];
    assign ent_addr  = pool_base_reg + (ADDR_W'(ent_base) << PAGE_SHIFT);
    assign credit    = FREE_W'(ent_pages) << PAGE_SHIFT;
    assign hit       = slot_valid[cmp_idx_reg] && (ent_addr == addr_reg);

    assign in_pool = (addr_reg >= pool_base_reg) &&
                     ({1'b0, addr_reg} <= ({1'b0, pool_base_reg} + {1'b0, pool_bytes_reg}));

    assign new_bytes = (cfg_index == CFG_POOL_BYTES) ? cfg_wdata : pool_bytes_reg;
    assign init_free = ({1'b0, new_bytes} >= ONE_PAGE) ? ({1'b0, new_bytes} - ONE_PAGE) : '0;

    assign wr_en   = (state_reg == ST_ALLOC) && !too_big && free_found && !past_end;
    assign wr_data = {bump_reg[BASE_W-1:0], PAGES_W'(need)};
    assign rd_addr = (state_reg == ST_SEARCH) ? SLOT_W'(cmp_idx_reg + 1'b1) : '0;

    vra_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (REGION_SLOTS)
    ) u_table (
        .clk   (aclk),
        .we    (wr_en),
        .waddr (free_idx),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    vra_slot_flags #(
        .SLOTS (REGION_SLOTS)
    ) u_flags (
        .clk        (aclk),
        .rst_n      (aresetn),
        .ctl        (slot_ctl),
        .clr_idx    (cmp_idx_reg),
        .valid      (slot_valid),
        .free_found (free_found),
        .free_idx   (free_idx)
    );

    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        size_next       = size_reg;
        addr_next       = addr_reg;
        pool_base_next  = pool_base_reg;
        pool_bytes_next = pool_bytes_reg;
        bump_next       = bump_reg;
        free_next       = free_reg;
        cmp_idx_next    = cmp_idx_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        res_pages_next  = res_pages_reg;
        res_legit_next  = res_legit_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_start_next    = m_start_reg;
        m_pages_next    = m_pages_reg;
        m_legit_next    = m_legit_reg;
        slot_ctl        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next     = req_t'(s_req_type);
                    size_next    = s_size_bytes;
                    addr_next    = s_address;
                    cmp_idx_next = '0;
                    if (req_t'(s_req_type) == REQ_ALLOC) begin
                        state_next = ST_ALLOC;
                    end else if (req_t'(s_req_type) == REQ_RELEASE) begin
                        state_next = ST_SEARCH;
                    end else begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_ALLOC: begin
                res_start_next = '0;
                res_pages_next = '0;
                res_legit_next = 1'b0;
                if (too_big) begin
                    res_status_next = STATUS_TOO_LARGE;
                end else if (!free_found) begin
                    res_status_next = STATUS_FULL;
                end else if (past_end) begin
                    res_status_next = STATUS_TOO_LARGE;
                end else begin
                    res_status_next = STATUS_OK;
                    res_start_next  = bump_addr;
                    res_pages_next  = PAGES_W'(need);
                    bump_next       = PAGES_W'(bump_sum);
                    free_next       = free_reg - rounded_pg;
                    slot_ctl.set    = 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_SEARCH: begin
                res_legit_next = 1'b0;
                if (hit) begin
                    res_status_next = STATUS_OK;
                    res_start_next  = addr_reg;
                    res_pages_next  = ent_pages;
                    free_next       = free_reg + credit;
                    slot_ctl.clr    = 1'b1;
                    state_next      = ST_DONE;
                end else if (cmp_idx_reg == LAST_SLOT) begin
                    res_status_next = STATUS_NOT_FOUND;
                    res_start_next  = '0;
                    res_pages_next  = '0;
                    state_next      = ST_DONE;
                end else begin
                    cmp_idx_next = cmp_idx_reg + 1'b1;
                end
            end
            ST_CHECK: begin
                res_status_next = STATUS_OK;
                res_start_next  = '0;
                res_pages_next  = '0;
                res_legit_next  = (req_reg == REQ_CHECK) && in_pool;
                state_next      = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_start_next  = res_start_reg;
                    m_pages_next  = res_pages_reg;
                    m_legit_next  = res_legit_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // register write reinitializes the pool
        if (cfg_we) begin
            if (cfg_index == CFG_POOL_BASE) begin
                pool_base_next = cfg_wdata;
            end else begin
                pool_bytes_next = cfg_wdata;
            end
            bump_next          = PAGES_W'(1);
            free_next          = init_free;
            slot_ctl.clear_all = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pool_base_reg  <= POOL_BASE_RST;
            pool_bytes_reg <= POOL_BYTES_RST;
            bump_reg       <= PAGES_W'(1);
            free_reg       <= FREE_W'(POOL_BYTES_RST) - ONE_PAGE;
            cmp_idx_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pool_base_reg  <= pool_base_next;
            pool_bytes_reg <= pool_bytes_next;
            bump_reg       <= bump_next;
            free_reg       <= free_next;
            cmp_idx_reg    <= cmp_idx_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        size_reg       <= size_next;
        addr_reg       <= addr_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
        res_pages_reg  <= res_pages_next;
        res_legit_reg  <= res_legit_next;
        m_status_reg   <= m_status_next;
        m_start_reg    <= m_start_next;
        m_pages_reg    <= m_pages_next;
        m_legit_reg    <= m_legit_next;
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_region_start = m_start_reg;
    assign m_region_pages = m_pages_reg;
    assign m_legitimate   = m_legit_reg;

endmodule

// ----- rtl/vra_checker.sv -----
module vra_checker
    import vra_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input logic [1:0]          m_status,
    input logic [ADDR_W-1:0]   m_region_start,
    input logic [PAGES_W-1:0]  m_region_pages,
    input logic                m_legitimate
);

    // no result beat right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat valid after reset");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) &&
            $stable(m_region_start) && $stable(m_region_pages) && $stable(m_legitimate))
        else $error("stalled result beat changed");

    // a rejected request reports no region
    a_reject_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != STATUS_OK) |-> (m_region_start == '0) &&
            (m_region_pages == '0) && !m_legitimate)
        else $error("rejected request carries region data");

    // a legitimate check never carries a region
    a_check_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_legitimate |-> (m_region_start == '0) && (m_region_pages == '0))
        else $error("check result carries region data");

endmodule

bind virtual_region_allocator_unit vra_checker u_vra_checker (.*);
